### rtl/core/helix_border_interval_query_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the helix border interval query block
// Implication, next-cycle implication and never-true checks on one clock.
// ----------------------------------------------------------------------------
`ifndef HELIX_BORDER_INTERVAL_QUERY_DEFINES_SVH
`define HELIX_BORDER_INTERVAL_QUERY_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HBIQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HBIQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define HBIQ_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define HBIQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define HBIQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`define HBIQ_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/hbiq_pkg.sv
// ----------------------------------------------------------------------------
// hbiq_pkg
// Field widths, codes, item types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package hbiq_pkg;

    localparam int REQ_W     = 2;
    localparam int POS_W     = 10;
    localparam int MARK_W    = 2;
    localparam int LEN_W     = 11;
    localparam int IDX_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSIDE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_OUTSIDE = 2'd2;

    localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LEFT  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HELIX_LENGTH   = 1'd1;

    localparam logic [LEN_W-1:0] PROFILE_LENGTH_RST = 11'd1024;
    localparam logic [LEN_W-1:0] HELIX_LENGTH_RST   = 11'd1024;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [MARK_W-1:0] mark;
    } request_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] last_pos;
        logic             inconsistent;
    } result_t;

    typedef enum logic [2:0] {
        FS_KEEP,
        FS_POS,
        FS_HIT,
        FS_HIT_INC,
        FS_ZERO
    } first_sel_t;

    typedef enum logic [2:0] {
        LS_ZERO,
        LS_POS,
        LS_HIT,
        LS_HIT_DEC,
        LS_LIM_DEC
    } last_sel_t;

    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       wr;
        logic       rd_pos;
        logic       scan_start;
        logic       scan_fwd;
        logic       scan_left;
        logic       scan_right;
        logic       scan;
        logic       emit;
        logic       found;
        logic       incons;
        first_sel_t first_sel;
        last_sel_t  last_sel;
    } cmd_t;

    typedef struct packed {
        logic              clr_last;
        logic              query_inside;
        logic              in_range;
        logic              scan_done;
        logic              scan_hit;
        logic [MARK_W-1:0] mark;
    } stat_t;

endpackage

### rtl/core/helix_border_interval_query.sv
// ----------------------------------------------------------------------------
// helix_border_interval_query
// Write items are done at accept; the next item is accepted in the following cycle.
// A query out of range raises done after the range check; otherwise the mark at its
// position is read and, where needed, the table is scanned below min(profile_length, DEPTH).
// busy falls with done, so the next item is taken at the edge that ends done.
// After reset busy stays high while the table is cleared;
// done is a one-cycle strobe and cannot be stalled.
// ----------------------------------------------------------------------------
module helix_border_interval_query #(
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  hbiq_pkg::request_t               request,
    output logic                             done,
    output hbiq_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [hbiq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbiq_pkg::LEN_W-1:0]       cfg_data
);

    hbiq_pkg::cmd_t  cmd;
    hbiq_pkg::stat_t stat;

    hbiq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    hbiq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

### rtl/core/hbiq_datapath.sv
// ----------------------------------------------------------------------------
// hbiq_datapath
// Mark table, config registers, scan address/tag pipeline and result register.
// ----------------------------------------------------------------------------
`include "helix_border_interval_query_defines.svh"

module hbiq_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hbiq_pkg::request_t                  request,
    input  logic                                cfg_we,
    input  logic [hbiq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbiq_pkg::LEN_W-1:0]          cfg_data,
    input  hbiq_pkg::cmd_t                      cmd,
    output hbiq_pkg::stat_t                     stat,
    output logic                                done,
    output hbiq_pkg::result_t                   result
);

    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = hbiq_pkg::IDX_W;
    localparam int PW      = hbiq_pkg::POS_W;
    localparam int MW      = hbiq_pkg::MARK_W;
    localparam int XW      = AW + IW;
    localparam int LIM_CAP = (DEPTH > (2 ** hbiq_pkg::LEN_W) - 1) ?
                             (2 ** hbiq_pkg::LEN_W) - 1 : DEPTH;

    logic [hbiq_pkg::LEN_W-1:0]  profile_length_reg;
    logic [hbiq_pkg::LEN_W-1:0]  helix_length_reg;
    logic [hbiq_pkg::REQ_W-1:0]  req_reg;
    logic [PW-1:0]               pos_reg;
    logic [AW-1:0]               clr_cnt_reg;
    logic [IW-1:0]               idx_reg;
    logic                        back_more_reg;
    logic                        scan_fwd_reg;
    logic                        scan_left_reg;
    logic                        scan_right_reg;
    logic                        rd_pend_reg;
    logic [IW-1:0]               rd_idx_reg;
    logic                        rd_in_mem_reg;
    logic [MW-1:0]               rdata_reg;
    logic [PW-1:0]               first_reg;
    logic                        done_reg;
    hbiq_pkg::result_t           result_reg;

    logic [MW-1:0]               mem [DEPTH];

    logic [IW-1:0]               lim;
    logic [IW-1:0]               lim_dec;
    logic [IW-1:0]               pos_ext;
    logic [MW-1:0]               mark_eff;
    logic                        hit;
    logic                        can_issue;
    logic                        issue;
    logic                        re_any;
    logic [IW-1:0]               rd_idx;
    logic                        rd_in;
    logic [XW-1:0]               rd_ext;
    logic [XW-1:0]               wr_ext;
    logic                        wr_in;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [MW-1:0]               mem_wdata;
    logic [PW-1:0]               hit_pos;
    logic [PW-1:0]               first_mux;
    logic [PW-1:0]               last_mux;

    // scan limit is the smaller of profile_length and the table depth
    assign lim     = (profile_length_reg < IW'(LIM_CAP)) ? profile_length_reg : IW'(LIM_CAP);
    assign lim_dec = lim - IW'(1);
    assign pos_ext = IW'(pos_reg);

    assign mark_eff  = rd_in_mem_reg ? rdata_reg : hbiq_pkg::MARK_NONE;
    assign hit       = rd_pend_reg &&
                       ((scan_left_reg && (mark_eff == hbiq_pkg::MARK_LEFT)) ||
                        (scan_right_reg && (mark_eff == hbiq_pkg::MARK_RIGHT)));
    assign can_issue = scan_fwd_reg ? (idx_reg < lim) : back_more_reg;
    assign issue     = cmd.scan && !cmd.scan_start && !hit && can_issue;

    // one table read per cycle; entries past the table read as no border
    assign re_any    = cmd.rd_pos || issue;
    assign rd_idx    = cmd.rd_pos ? pos_ext : idx_reg;
    assign rd_in     = 32'(rd_idx) < DEPTH;
    assign rd_ext    = XW'(rd_idx);
    assign mem_raddr = rd_ext[AW-1:0];
    assign mem_re    = re_any && rd_in;

    assign wr_ext    = XW'(request.position);
    assign wr_in     = 32'(request.position) < DEPTH;
    assign mem_we    = cmd.clr_step || (cmd.wr && wr_in);
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : wr_ext[AW-1:0];
    assign mem_wdata = cmd.clr_step ? hbiq_pkg::MARK_NONE : request.mark;

    assign hit_pos   = rd_idx_reg[PW-1:0];

    always_comb
    begin
        unique case (cmd.first_sel)
            hbiq_pkg::FS_KEEP:    first_mux = first_reg;
            hbiq_pkg::FS_POS:     first_mux = pos_reg;
            hbiq_pkg::FS_HIT:     first_mux = hit_pos;
            hbiq_pkg::FS_HIT_INC: first_mux = hit_pos + PW'(1);
            hbiq_pkg::FS_ZERO:    first_mux = '0;
            default:              first_mux = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.last_sel)
            hbiq_pkg::LS_ZERO:    last_mux = '0;
            hbiq_pkg::LS_POS:     last_mux = pos_reg;
            hbiq_pkg::LS_HIT:     last_mux = hit_pos;
            hbiq_pkg::LS_HIT_DEC: last_mux = hit_pos - PW'(1);
            hbiq_pkg::LS_LIM_DEC: last_mux = lim_dec[PW-1:0];
            default:              last_mux = '0;
        endcase
    end

    always_comb
    begin
        stat.clr_last     = (clr_cnt_reg == AW'(DEPTH - 1));
        stat.query_inside = (req_reg == hbiq_pkg::REQ_INSIDE);
        stat.in_range     = (pos_ext < lim) && (pos_ext < helix_length_reg);
        stat.scan_done    = hit || (!rd_pend_reg && !can_issue);
        stat.scan_hit     = hit;
        stat.mark         = mark_eff;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_length_reg <= hbiq_pkg::PROFILE_LENGTH_RST;
            helix_length_reg   <= hbiq_pkg::HELIX_LENGTH_RST;
            clr_cnt_reg        <= '0;
            rd_pend_reg        <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == hbiq_pkg::CFG_PROFILE_LENGTH))
            begin
                profile_length_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == hbiq_pkg::CFG_HELIX_LENGTH))
            begin
                helix_length_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            rd_pend_reg <= cmd.rd_pos || issue;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request.req_type;
            pos_reg <= request.position;
        end
        if (cmd.scan_start)
        begin
            scan_fwd_reg   <= cmd.scan_fwd;
            scan_left_reg  <= cmd.scan_left;
            scan_right_reg <= cmd.scan_right;
            idx_reg        <= cmd.scan_fwd ? pos_ext + IW'(1) : pos_ext - IW'(1);
            back_more_reg  <= (pos_reg != '0);
        end
        else if (issue)
        begin
            if (scan_fwd_reg)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            else if (idx_reg == '0)
            begin
                back_more_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IW'(1);
            end
        end
        if (re_any)
        begin
            rd_idx_reg    <= rd_idx;
            rd_in_mem_reg <= rd_in;
        end
        if (cmd.first_sel != hbiq_pkg::FS_KEEP)
        begin
            first_reg <= first_mux;
        end
        if (cmd.emit)
        begin
            result_reg.found        <= cmd.found;
            result_reg.first_pos    <= cmd.found ? first_mux : '0;
            result_reg.last_pos     <= cmd.found ? last_mux : '0;
            result_reg.inconsistent <= cmd.incons;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `HBIQ_ASSERT_IMPL(a_found_not_incons, clk, rst_n, done_reg && result_reg.found, !result_reg.inconsistent, "found result flagged inconsistent")
    `HBIQ_ASSERT_IMPL(a_miss_zero_pos, clk, rst_n, done_reg && !result_reg.found, (result_reg.first_pos == '0) && (result_reg.last_pos == '0), "not-found result has nonzero bounds")
    `HBIQ_ASSERT_NEVER(a_mem_one_port, clk, rst_n, mem_we && mem_re, "table read and write in one cycle")

endmodule

### rtl/core/hbiq_ctrl.sv
// ----------------------------------------------------------------------------
// hbiq_ctrl
// Sequencer: clearing pass, item accept, range check, mark lookup and the scan phases.
// ----------------------------------------------------------------------------
`include "helix_border_interval_query_defines.svh"

module hbiq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [hbiq_pkg::REQ_W-1:0]       req_type,
    input  hbiq_pkg::stat_t                  stat,
    output logic                             busy,
    output hbiq_pkg::cmd_t                   cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LOOK,
        ST_IL_FWD,
        ST_IR_BACK,
        ST_IN_BACK,
        ST_IN_FWD,
        ST_OUT_BACK,
        ST_OUT_FWD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.first_sel = hbiq_pkg::FS_KEEP;
        cmd.last_sel  = hbiq_pkg::LS_ZERO;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (req_type == hbiq_pkg::REQ_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else if ((req_type == hbiq_pkg::REQ_INSIDE) ||
                             (req_type == hbiq_pkg::REQ_OUTSIDE))
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.rd_pos = 1'b1;
                if (!stat.in_range)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.query_inside)
                begin
                    cmd.scan_start = 1'b1;
                    if (stat.mark == hbiq_pkg::MARK_LEFT)
                    begin
                        cmd.scan_fwd   = 1'b1;
                        cmd.scan_right = 1'b1;
                        state_next     = ST_IL_FWD;
                    end
                    else if (stat.mark == hbiq_pkg::MARK_RIGHT)
                    begin
                        cmd.scan_left = 1'b1;
                        state_next    = ST_IR_BACK;
                    end
                    else
                    begin
                        cmd.scan_left  = 1'b1;
                        cmd.scan_right = 1'b1;
                        state_next     = ST_IN_BACK;
                    end
                end
                else if ((stat.mark == hbiq_pkg::MARK_LEFT) ||
                         (stat.mark == hbiq_pkg::MARK_RIGHT))
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_left  = 1'b1;
                    cmd.scan_right = 1'b1;
                    state_next     = ST_OUT_BACK;
                end
            end
            ST_IL_FWD:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.emit   = 1'b1;
                    cmd.found  = stat.scan_hit;
                    cmd.incons = !stat.scan_hit;
                    cmd.first_sel = hbiq_pkg::FS_POS;
                    cmd.last_sel  = hbiq_pkg::LS_HIT;
                    state_next = ST_IDLE;
                end
            end
            ST_IR_BACK:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.emit   = 1'b1;
                    cmd.found  = stat.scan_hit;
                    cmd.incons = !stat.scan_hit;
                    cmd.first_sel = hbiq_pkg::FS_HIT;
                    cmd.last_sel  = hbiq_pkg::LS_POS;
                    state_next = ST_IDLE;
                end
            end
            ST_IN_BACK:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    // left border behind us: look ahead for its right partner
                    if (stat.scan_hit && (stat.mark == hbiq_pkg::MARK_LEFT))
                    begin
                        cmd.first_sel  = hbiq_pkg::FS_HIT;
                        cmd.scan_start = 1'b1;
                        cmd.scan_fwd   = 1'b1;
                        cmd.scan_left  = 1'b1;
                        cmd.scan_right = 1'b1;
                        state_next     = ST_IN_FWD;
                    end
                    else
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IN_FWD:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.emit     = 1'b1;
                    cmd.found    = stat.scan_hit && (stat.mark == hbiq_pkg::MARK_RIGHT);
                    cmd.incons   = !(stat.scan_hit && (stat.mark == hbiq_pkg::MARK_RIGHT));
                    cmd.last_sel = hbiq_pkg::LS_HIT;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT_BACK:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.scan_hit && (stat.mark == hbiq_pkg::MARK_LEFT))
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // gap starts after a right border, or at 0
                        cmd.first_sel  = stat.scan_hit ? hbiq_pkg::FS_HIT_INC :
                                                         hbiq_pkg::FS_ZERO;
                        cmd.scan_start = 1'b1;
                        cmd.scan_fwd   = 1'b1;
                        cmd.scan_left  = 1'b1;
                        cmd.scan_right = 1'b1;
                        state_next     = ST_OUT_FWD;
                    end
                end
            end
            ST_OUT_FWD:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.emit = 1'b1;
                    if (stat.scan_hit && (stat.mark == hbiq_pkg::MARK_RIGHT))
                    begin
                        cmd.incons = 1'b1;
                    end
                    else
                    begin
                        cmd.found    = 1'b1;
                        cmd.last_sel = stat.scan_hit ? hbiq_pkg::LS_HIT_DEC :
                                                       hbiq_pkg::LS_LIM_DEC;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

    `HBIQ_ASSERT_NEXT(a_emit_to_idle, clk, rst_n, cmd.emit, state_reg == ST_IDLE, "result emitted without returning to idle")
    `HBIQ_ASSERT_IMPL(a_check_from_idle, clk, rst_n, state_reg == ST_CHECK, $past(state_reg) == ST_IDLE, "range check entered not from idle")
    `HBIQ_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && ((req_type == hbiq_pkg::REQ_INSIDE) || (req_type == hbiq_pkg::REQ_OUTSIDE)), busy, "accepted query did not raise busy")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: helix_border_interval_query testbench
// Builds border marks with write items and checks inside and outside interval
// queries against an in-bench predictor of the mark table. A short directed
// table runs first, then random phases at several length settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hbiq_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WIN   = 64;      // window width for clustered random traffic

    // request code with no function, and the mark code that reads as no border
    localparam logic [REQ_W-1:0]  REQ_SPARE  = 2'd3;
    localparam logic [MARK_W-1:0] MARK_SPARE = 2'd3;

    localparam result_t NO_HIT    = '0;
    localparam result_t UNMATCHED = '{found: 1'b0, first_pos: '0, last_pos: '0,
                                      inconsistent: 1'b1};
    localparam result_t WHOLE_GAP = '{found: 1'b1, first_pos: '0, last_pos: 10'd1023,
                                      inconsistent: 1'b0};

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        int                   cfg_val;
        logic [REQ_W-1:0]     rq;
        int                   pos;
        logic [MARK_W-1:0]    mk;
        bit                   typed;
        result_t              want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    request_t             request = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;

    logic [MARK_W-1:0] mark_table [DEPTH];
    logic [LEN_W-1:0]  cur_plen;
    logic [LEN_W-1:0]  cur_hlen;
    result_t           pending_results [$];
    dir_row_t          dir_rows [$];
    int                n_errors = 0;
    bit                idle_on = 1'b1;

    helix_border_interval_query #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // first index above pos (below lim) holding mark a or b, lim if none
    function automatic int scan_up(int pos, int lim, logic [MARK_W-1:0] a,
                                   logic [MARK_W-1:0] b);
        for (int i = pos + 1; i < lim; i++)
        begin
            if (mark_table[i] == a || mark_table[i] == b)
                return i;
        end
        return lim;
    endfunction

    // index+1 of the nearest entry below pos holding a or b, 0 if none
    function automatic int scan_down(int pos, logic [MARK_W-1:0] a, logic [MARK_W-1:0] b);
        for (int i = pos; i > 0; i--)
        begin
            if (mark_table[i-1] == a || mark_table[i-1] == b)
                return i;
        end
        return 0;
    endfunction

    function automatic result_t predict_interval(logic [REQ_W-1:0] rq, int pos);
        result_t           r;
        int                lim;
        int                j;
        int                k;
        logic [MARK_W-1:0] m;
        r = '0;
        lim = (cur_plen < DEPTH) ? int'(cur_plen) : DEPTH;
        if (pos >= lim || pos >= int'(cur_hlen))
            return r;
        m = mark_table[pos];
        if (rq == REQ_INSIDE)
        begin
            if (m == MARK_LEFT)
            begin
                j = scan_up(pos, lim, MARK_RIGHT, MARK_RIGHT);
                if (j < lim)
                begin
                    r.found     = 1'b1;
                    r.first_pos = POS_W'(pos);
                    r.last_pos  = POS_W'(j);
                end
                else
                begin
                    r.inconsistent = 1'b1;
                end
            end
            else if (m == MARK_RIGHT)
            begin
                k = scan_down(pos, MARK_LEFT, MARK_LEFT);
                if (k > 0)
                begin
                    r.found     = 1'b1;
                    r.first_pos = POS_W'(k - 1);
                    r.last_pos  = POS_W'(pos);
                end
                else
                begin
                    r.inconsistent = 1'b1;
                end
            end
            else
            begin
                k = scan_down(pos, MARK_LEFT, MARK_RIGHT);
                if (k > 0 && mark_table[k-1] == MARK_LEFT)
                begin
                    j = scan_up(pos, lim, MARK_LEFT, MARK_RIGHT);
                    if (j < lim && mark_table[j] == MARK_RIGHT)
                    begin
                        r.found     = 1'b1;
                        r.first_pos = POS_W'(k - 1);
                        r.last_pos  = POS_W'(j);
                    end
                    else
                    begin
                        r.inconsistent = 1'b1;
                    end
                end
            end
        end
        else if (m != MARK_LEFT && m != MARK_RIGHT)
        begin
            k = scan_down(pos, MARK_LEFT, MARK_RIGHT);
            if (k == 0 || mark_table[k-1] == MARK_RIGHT)
            begin
                j = scan_up(pos, lim, MARK_LEFT, MARK_RIGHT);
                if (j < lim && mark_table[j] == MARK_RIGHT)
                begin
                    r.inconsistent = 1'b1;
                end
                else
                begin
                    r.found     = 1'b1;
                    r.first_pos = POS_W'(k);
                    r.last_pos  = POS_W'(j - 1);
                end
            end
        end
        return r;
    endfunction

    // drive one item and hold it until busy is low; the caller owns start afterwards
    task automatic send(input logic [REQ_W-1:0] rq, input int pos,
                        input logic [MARK_W-1:0] mk, input bit typed = 1'b0,
                        input result_t want = '0);
        request_t item;
        item.req_type = rq;
        item.position = POS_W'(pos);
        item.mark     = mk;
        if (idle_on)
        begin
            while ($urandom_range(99, 0) < 32)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (rq)
            REQ_WRITE:
                mark_table[pos] = mk;
            REQ_INSIDE, REQ_OUTSIDE:
                pending_results.push_back(typed ? want : predict_interval(rq, pos));
            default:
                ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a trailing write item may still be in flight
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= LEN_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PROFILE_LENGTH)
            cur_plen = LEN_W'(val);
        else
            cur_hlen = LEN_W'(val);
    endtask

    function automatic void add_item(logic [REQ_W-1:0] rq, int pos, logic [MARK_W-1:0] mk,
                                     bit typed = 1'b0, result_t want = '0);
        dir_rows.push_back('{1'b0, CFG_PROFILE_LENGTH, 0, rq, pos, mk, typed, want});
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        dir_rows.push_back('{1'b1, idx, val, REQ_WRITE, 0, MARK_NONE, 1'b0, NO_HIT});
    endfunction

    task automatic run_phase(input int plen, input int hlen, input int n_items,
                             input bit gaps);
        int hi;
        int base;
        int a;
        int w;
        int nq;
        int pick;
        int sent;
        write_reg(CFG_PROFILE_LENGTH, plen);
        write_reg(CFG_HELIX_LENGTH, hlen);
        idle_on = gaps;
        hi   = (plen > WIN) ? plen : WIN;
        base = $urandom_range(hi - WIN, 0);
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 40)
            begin
                // well-formed helix, then queries around it
                a  = base + $urandom_range(WIN - 17, 0);
                w  = $urandom_range(14, 1);
                nq = $urandom_range(3, 1);
                send(REQ_WRITE, a, MARK_LEFT);
                send(REQ_WRITE, a + w, MARK_RIGHT);
                repeat (nq)
                    send($urandom_range(1, 0) ? REQ_INSIDE : REQ_OUTSIDE,
                         base + $urandom_range(WIN - 1, 0), MARK_W'($urandom_range(3, 0)));
                sent += 2 + nq;
            end
            else if (pick < 65)
            begin
                send($urandom_range(1, 0) ? REQ_INSIDE : REQ_OUTSIDE,
                     base + $urandom_range(WIN - 1, 0), MARK_W'($urandom_range(3, 0)));
                sent++;
            end
            else if (pick < 85)
            begin
                // stray or clearing marks, code three included
                send(REQ_WRITE, base + $urandom_range(WIN - 1, 0),
                     MARK_W'($urandom_range(3, 0)));
                sent++;
            end
            else if (pick < 93)
            begin
                send(REQ_SPARE, $urandom_range(DEPTH - 1, 0), MARK_W'($urandom_range(3, 0)));
            end
            else
            begin
                send(REQ_W'($urandom_range(2, 0)), $urandom_range(DEPTH - 1, 0),
                     MARK_W'($urandom_range(3, 0)));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                flag_error("result with no query outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found)
                    flag_error($sformatf("found %0b, want %0b", result.found, want.found));
                if (result.first_pos !== want.first_pos)
                    flag_error($sformatf("first_pos %0d, want %0d",
                                         result.first_pos, want.first_pos));
                if (result.last_pos !== want.last_pos)
                    flag_error($sformatf("last_pos %0d, want %0d",
                                         result.last_pos, want.last_pos));
                if (result.inconsistent !== want.inconsistent)
                    flag_error($sformatf("inconsistent %0b, want %0b",
                                         result.inconsistent, want.inconsistent));
            end
        end
    end

    initial
    begin
        foreach (mark_table[i])
            mark_table[i] = MARK_NONE;
        cur_plen = PROFILE_LENGTH_RST;
        cur_hlen = HELIX_LENGTH_RST;

        // empty table at reset lengths
        add_item(REQ_INSIDE, 0, MARK_NONE, 1'b1, NO_HIT);
        add_item(REQ_OUTSIDE, 1023, MARK_NONE, 1'b1, WHOLE_GAP);
        // one helix 5..9
        add_item(REQ_WRITE, 5, MARK_LEFT);
        add_item(REQ_WRITE, 9, MARK_RIGHT);
        add_item(REQ_INSIDE, 7, MARK_NONE);
        add_item(REQ_INSIDE, 5, MARK_NONE);
        add_item(REQ_INSIDE, 9, MARK_NONE);
        add_item(REQ_OUTSIDE, 3, MARK_NONE);
        add_item(REQ_OUTSIDE, 12, MARK_NONE);
        add_item(REQ_OUTSIDE, 7, MARK_NONE);
        add_item(REQ_OUTSIDE, 5, MARK_NONE);
        // borders with no partner at both table ends
        add_item(REQ_WRITE, 1023, MARK_LEFT);
        add_item(REQ_INSIDE, 1023, MARK_NONE, 1'b1, UNMATCHED);
        add_item(REQ_WRITE, 0, MARK_RIGHT);
        add_item(REQ_INSIDE, 0, MARK_NONE, 1'b1, UNMATCHED);
        // mark code three reads as no border
        add_item(REQ_WRITE, 20, MARK_SPARE);
        add_item(REQ_INSIDE, 20, MARK_NONE);
        // two lefts in a row, then a right after a right
        add_item(REQ_WRITE, 30, MARK_LEFT);
        add_item(REQ_WRITE, 40, MARK_LEFT);
        add_item(REQ_INSIDE, 35, MARK_NONE);
        add_item(REQ_WRITE, 25, MARK_RIGHT);
        add_item(REQ_OUTSIDE, 15, MARK_NONE);
        add_item(REQ_SPARE, 1023, MARK_SPARE);
        // position past helix_length, then a scan cut short by profile_length
        add_cfg(CFG_HELIX_LENGTH, 0);
        add_item(REQ_INSIDE, 7, MARK_NONE, 1'b1, NO_HIT);
        add_cfg(CFG_HELIX_LENGTH, 1024);
        add_cfg(CFG_PROFILE_LENGTH, 38);
        add_item(REQ_INSIDE, 35, MARK_NONE);
        add_item(REQ_OUTSIDE, 38, MARK_NONE, 1'b1, NO_HIT);
        add_cfg(CFG_PROFILE_LENGTH, 1024);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            else
                send(dir_rows[i].rq, dir_rows[i].pos, dir_rows[i].mk,
                     dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(1024, 1024, 80, 1'b1);
        run_phase(1, 1024, 50, 1'b1);
        run_phase(1024, 0, 50, 1'b1);
        run_phase(64, 1024, 90, 1'b0);
        run_phase(1000, 700, 80, 1'b1);
        run_phase($urandom_range(1024, 1), $urandom_range(1024, 0), 80, 1'b1);
        run_phase(1024, 1024, 120, 1'b1);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 80) @(posedge clk);
        if (n_errors == 0)
            $display("helix_border_interval_query test passed");
        else
            $display("helix_border_interval_query test failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("helix_border_interval_query test failed");
        $finish;
    end

endmodule
